// ===== rtl/bpu_pkg.sv =====
// ----------------------------------------------------------------------------
// bpu_pkg
// shared constants, codes and the pixel record of the bitmap pixel unpacker
// ----------------------------------------------------------------------------
package bpu_pkg;

  // image and colour table limits
  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int TABLE_DEPTH = 256;

  localparam int ByteW    = 8;
  localparam int CoordW   = 12;
  localparam int DimW     = 13;
  localparam int FmtW     = 2;
  localparam int ColourW  = 3 * ByteW;
  localparam int TabAw    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = DimW;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAw    = $clog2(QDEPTH);
  localparam int QCntW  = QAw + 1;

  // pixel formats (code 3 behaves as 32 bpp)
  localparam logic [FmtW-1:0] FMT_IDX8   = 2'd0;
  localparam logic [FmtW-1:0] FMT_BGR24  = 2'd1;
  localparam logic [FmtW-1:0] FMT_BGRA32 = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_FORMAT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TOP_DOWN = 2'd3;

  // request kinds
  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  localparam logic [ByteW-1:0] OPAQUE = 8'd255;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              last;
    logic [ByteW-1:0]  red;
    logic [ByteW-1:0]  green;
    logic [ByteW-1:0]  blue;
    logic [ByteW-1:0]  alpha;
  } pix_t;

endpackage

// ===== rtl/bpu_ram.sv =====
// ----------------------------------------------------------------------------
// bpu_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bpu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bpu_front.sv =====
// ----------------------------------------------------------------------------
// bpu_front
// accepts requests, keeps the colour table, assembles pixel bytes, skips
// row padding and tracks coordinates; one completed pixel per cycle at most
// ----------------------------------------------------------------------------
module bpu_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_req_type,
  input  logic [bpu_pkg::ByteW-1:0]      in_data_byte,
  input  logic [bpu_pkg::ByteW-1:0]      in_palette_index,
  input  logic [bpu_pkg::ByteW-1:0]      in_palette_red,
  input  logic [bpu_pkg::ByteW-1:0]      in_palette_green,
  input  logic [bpu_pkg::ByteW-1:0]      in_palette_blue,
  input  logic                           cfg_we,
  input  logic [bpu_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bpu_pkg::CfgDataW-1:0]   cfg_wdata,
  input  logic [bpu_pkg::QCntW-1:0]      q_count,
  output logic                           pix_valid,
  output bpu_pkg::pix_t                  pix
);
  import bpu_pkg::*;

  // configuration
  logic [FmtW-1:0]   fmt_r;
  logic [CoordW-1:0] wlast_r;
  logic [CoordW-1:0] hlast_r;
  logic              top_down_r;

  // stream state
  logic [ColourW-1:0] holder_r, holder_nxt;
  logic [1:0]         bip_r, bip_nxt;
  logic [CoordW-1:0]  col_r, col_nxt;
  logic [CoordW-1:0]  row_r, row_nxt;
  logic [1:0]         pad_r, pad_nxt;

  // stage register, lines up with the registered ram read
  logic       stage_v_r, stage_v_nxt;
  pix_t       job_r, job_nxt;
  logic       ind_r, ind_nxt;
  logic       idx_ok_r, idx_ok_nxt;

  logic               acc;
  logic               pix_byte;
  logic               done;
  logic [1:0]         w_low;
  logic [1:0]         pad_len;
  logic               ram_we;
  logic [ColourW-1:0] ram_rdata;

  function automatic logic [CoordW-1:0] dim_last(input logic [DimW-1:0] v,
                                                 input int unsigned      max_v);
    logic [CoordW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > DimW'(max_v)) begin
      res = CoordW'(max_v - 1);
    end else begin
      res = CoordW'(v - DimW'(1));
    end
    return res;
  endfunction

  // room must exist for the item in the stage and one more
  assign in_full = ((QCntW + 1)'(q_count) + (QCntW + 1)'(stage_v_r)) >=
                   (QCntW + 1)'(QDEPTH);

  assign acc      = in_push && !in_full;
  assign pix_byte = acc && (in_req_type == REQ_PIXEL);

  assign ram_we = acc && (in_req_type == REQ_PALETTE) &&
                  ({1'b0, in_palette_index} < (ByteW + 1)'(TABLE_DEPTH));

  bpu_ram #(
    .WIDTH(ColourW),
    .DEPTH(TABLE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_palette_index[TabAw-1:0]),
    .wdata({in_palette_red, in_palette_green, in_palette_blue}),
    .raddr(in_data_byte[TabAw-1:0]),
    .rdata(ram_rdata)
  );

  assign w_low = wlast_r[1:0] + 2'd1;

  always_comb begin
    priority if (fmt_r == FMT_IDX8) begin
      pad_len = 2'd0 - w_low;
    end else if (fmt_r == FMT_BGR24) begin
      pad_len = w_low;
    end else begin
      pad_len = 2'd0;
    end
  end

  always_comb begin
    holder_nxt  = holder_r;
    bip_nxt     = bip_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    pad_nxt     = pad_r;
    stage_v_nxt = 1'b0;
    job_nxt     = job_r;
    ind_nxt     = ind_r;
    idx_ok_nxt  = idx_ok_r;
    done        = 1'b0;

    if (pix_byte) begin
      if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
      end else begin
        unique case (fmt_r)
          FMT_IDX8: begin
            done          = 1'b1;
            ind_nxt       = 1'b1;
            idx_ok_nxt    = {1'b0, in_data_byte} < (ByteW + 1)'(TABLE_DEPTH);
            job_nxt.red   = '0;
            job_nxt.green = '0;
            job_nxt.blue  = '0;
            job_nxt.alpha = OPAQUE;
          end
          FMT_BGR24: begin
            if (bip_r < 2'd2) begin
              holder_nxt = holder_r | (ColourW'(in_data_byte) << {bip_r, 3'b000});
              bip_nxt    = bip_r + 2'd1;
            end else begin
              done          = 1'b1;
              ind_nxt       = 1'b0;
              idx_ok_nxt    = 1'b1;
              job_nxt.red   = in_data_byte;
              job_nxt.green = holder_r[15:8];
              job_nxt.blue  = holder_r[7:0];
              job_nxt.alpha = OPAQUE;
            end
          end
          default: begin
            if (bip_r < 2'd3) begin
              holder_nxt = holder_r | (ColourW'(in_data_byte) << {bip_r, 3'b000});
              bip_nxt    = bip_r + 2'd1;
            end else begin
              done          = 1'b1;
              ind_nxt       = 1'b0;
              idx_ok_nxt    = 1'b1;
              job_nxt.red   = holder_r[23:16];
              job_nxt.green = holder_r[15:8];
              job_nxt.blue  = holder_r[7:0];
              job_nxt.alpha = in_data_byte;
            end
          end
        endcase

        if (done) begin
          holder_nxt   = '0;
          bip_nxt      = '0;
          stage_v_nxt  = 1'b1;
          job_nxt.x    = col_r;
          job_nxt.y    = top_down_r ? row_r : (hlast_r - row_r);
          job_nxt.last = (col_r == wlast_r) && (row_r == hlast_r);
          if (col_r == wlast_r) begin
            col_nxt = '0;
            pad_nxt = pad_len;
            row_nxt = (row_r == hlast_r) ? '0 : (row_r + CoordW'(1));
          end else begin
            col_nxt = col_r + CoordW'(1);
          end
        end
      end
    end

    // any register write restarts the frame
    if (cfg_we) begin
      holder_nxt = '0;
      bip_nxt    = '0;
      col_nxt    = '0;
      row_nxt    = '0;
      pad_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r      <= FMT_BGR24;
      wlast_r    <= '0;
      hlast_r    <= '0;
      top_down_r <= 1'b0;
      holder_r   <= '0;
      bip_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      pad_r      <= '0;
      stage_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FORMAT:   fmt_r      <= cfg_wdata[FmtW-1:0];
          REG_WIDTH:    wlast_r    <= dim_last(cfg_wdata, MAX_WIDTH);
          REG_HEIGHT:   hlast_r    <= dim_last(cfg_wdata, MAX_HEIGHT);
          REG_TOP_DOWN: top_down_r <= cfg_wdata[0];
          default:      top_down_r <= top_down_r;
        endcase
      end
      holder_r  <= holder_nxt;
      bip_r     <= bip_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      pad_r     <= pad_nxt;
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    ind_r    <= ind_nxt;
    idx_ok_r <= idx_ok_nxt;
  end

  // indexed pixels pick up their colour from the table read
  always_comb begin
    pix = job_r;
    if (ind_r) begin
      pix.red   = idx_ok_r ? ram_rdata[23:16] : '0;
      pix.green = idx_ok_r ? ram_rdata[15:8]  : '0;
      pix.blue  = idx_ok_r ? ram_rdata[7:0]   : '0;
    end
  end

  assign pix_valid = stage_v_r;

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    stage_v_r |-> (q_count < QCntW'(QDEPTH)))
    else $error("pixel pushed into a full queue");

  a_palette_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_req_type == REQ_PALETTE)) |=> !stage_v_r)
    else $error("palette write produced a pixel");

  a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r && job_r.last) |-> (job_r.x == wlast_r))
    else $error("last pixel not in the last column");

endmodule

// ===== rtl/bpu_queue.sv =====
// ----------------------------------------------------------------------------
// bpu_queue
// short pixel queue that decouples the front from the back
// ----------------------------------------------------------------------------
module bpu_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  bpu_pkg::pix_t             din,
  input  logic                      pop,
  output bpu_pkg::pix_t             dout,
  output logic                      not_empty,
  output logic [bpu_pkg::QCntW-1:0] count
);
  import bpu_pkg::*;

  pix_t             slot_r [QDEPTH];
  logic [QAw-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? (wr_ptr_r + QAw'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop  ? (rd_ptr_r + QAw'(1)) : rd_ptr_r;
    count_nxt  = count_r + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  assign dout      = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from an empty queue");

endmodule

// ===== rtl/bpu_back.sv =====
// ----------------------------------------------------------------------------
// bpu_back
// applies the magenta colour key and holds the result register
// ----------------------------------------------------------------------------
module bpu_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  bpu_pkg::pix_t              q_data,
  output logic                       q_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [bpu_pkg::CoordW-1:0] out_pixel_x,
  output logic [bpu_pkg::CoordW-1:0] out_pixel_y,
  output logic [bpu_pkg::ByteW-1:0]  out_red,
  output logic [bpu_pkg::ByteW-1:0]  out_green,
  output logic [bpu_pkg::ByteW-1:0]  out_blue,
  output logic [bpu_pkg::ByteW-1:0]  out_alpha,
  output logic                       out_last_pixel
);
  import bpu_pkg::*;

  logic out_v_r, out_v_nxt;
  pix_t out_r, out_nxt;
  logic keyed;

  assign keyed = (q_data.red == 8'hFF) && (q_data.green == 8'h00) &&
                 (q_data.blue == 8'hFF);

  // refill the result register when it is empty or being taken
  assign q_pop = q_valid && (!out_v_r || out_pop);

  always_comb begin
    out_nxt = q_data;
    if (keyed) begin
      out_nxt.alpha = '0;
    end
    if (q_pop) begin
      out_v_nxt = 1'b1;
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

  assign out_empty      = !out_v_r;
  assign out_pixel_x    = out_r.x;
  assign out_pixel_y    = out_r.y;
  assign out_red        = out_r.red;
  assign out_green      = out_r.green;
  assign out_blue       = out_r.blue;
  assign out_alpha      = out_r.alpha;
  assign out_last_pixel = out_r.last;

  a_key_applied: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_r.red == 8'hFF) && (out_r.green == 8'h00) &&
     (out_r.blue == 8'hFF)) |-> (out_r.alpha == 8'h00))
    else $error("magenta pixel left opaque");

endmodule

// ===== rtl/bitmap_pixel_unpacker.sv =====
// ----------------------------------------------------------------------------
// bitmap_pixel_unpacker
// The unpacker takes one request per clock while in_full is low: a colour
// table write or one raw byte of bitmap pixel data. The pixel that a taken
// byte completes enters a stage register that lines up with the registered
// colour table read, is then written into the pixel queue and from there
// reaches the result register once that is empty or being popped. The front
// keeps taking bytes while results wait, until its four-entry pixel queue
// has no room left, so with pop held high the stream runs at one byte per
// cycle indefinitely. Register writes restart the frame; the user must make
// them only while the block is idle, as the block itself does not enforce
// this. The colour table needs no clearing after reset.
// ----------------------------------------------------------------------------
module bitmap_pixel_unpacker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_req_type,
  input  logic [bpu_pkg::ByteW-1:0]    in_data_byte,
  input  logic [bpu_pkg::ByteW-1:0]    in_palette_index,
  input  logic [bpu_pkg::ByteW-1:0]    in_palette_red,
  input  logic [bpu_pkg::ByteW-1:0]    in_palette_green,
  input  logic [bpu_pkg::ByteW-1:0]    in_palette_blue,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [bpu_pkg::CoordW-1:0]   out_pixel_x,
  output logic [bpu_pkg::CoordW-1:0]   out_pixel_y,
  output logic [bpu_pkg::ByteW-1:0]    out_red,
  output logic [bpu_pkg::ByteW-1:0]    out_green,
  output logic [bpu_pkg::ByteW-1:0]    out_blue,
  output logic [bpu_pkg::ByteW-1:0]    out_alpha,
  output logic                         out_last_pixel,
  input  logic                         cfg_we,
  input  logic [bpu_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bpu_pkg::CfgDataW-1:0] cfg_wdata
);
  import bpu_pkg::*;

  logic             pix_valid;
  pix_t             pix;
  logic             q_pop;
  logic             q_not_empty;
  pix_t             q_data;
  logic [QCntW-1:0] q_count;

  bpu_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_req_type     (in_req_type),
    .in_data_byte    (in_data_byte),
    .in_palette_index(in_palette_index),
    .in_palette_red  (in_palette_red),
    .in_palette_green(in_palette_green),
    .in_palette_blue (in_palette_blue),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .q_count         (q_count),
    .pix_valid       (pix_valid),
    .pix             (pix)
  );

  bpu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (pix_valid),
    .din      (pix),
    .pop      (q_pop),
    .dout     (q_data),
    .not_empty(q_not_empty),
    .count    (q_count)
  );

  bpu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_not_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_last_pixel(out_last_pixel)
  );

endmodule
